>>> rtl/pcvh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcvh_pkg: shared types and microcode for the polygon convex hull scan
// Item structs, stack/step/condition codes and the control store contents.
// ----------------------------------------------------------------------------
package pcvh_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SEED_COUNT   = 3;   // vertices pushed without a turn test
  localparam int T2_OFFSET    = 2;   // second entry from the top

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // most negative coordinate: any first vertex beats it
  localparam coord_t TOP_Y_RESET = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
  } in_item_t;

  typedef struct packed {
    coord_t hull_x;
    coord_t hull_y;
    logic   hull_last;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_FETCH, S_LOADV, S_RDT2, S_LDT2, S_MULA, S_MULB,
    S_TEST, S_POP, S_PUSH, S_RDK, S_OUT, S_DONE
  } step_t;

  typedef enum logic [3:0] {
    UOP_NOP, UOP_INIT, UOP_FETCH, UOP_LOADV, UOP_RDT2, UOP_LDT2, UOP_MULA,
    UOP_MULB, UOP_POP, UOP_PUSH, UOP_RDK, UOP_OUT, UOP_DONE
  } uop_t;

  typedef enum logic [2:0] {
    C_NONE, C_ALWAYS, C_NOGO, C_SEED, C_NOPOP, C_DEEP, C_MORE, C_EMORE
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic go;      // last vertex of a run accepted
    logic seed;    // current vertex is one of the seeds
    logic nopop;   // turn test passes, no pop needed
    logic deep;    // stack can still pop after this pop
    logic more;    // vertices remain to scan
    logic emore;   // hull entries remain to emit
  } status_t;

  // control store: a true condition jumps to target, else fall through
  function automatic ctrl_word_t ucode_rom(step_t s);
    ctrl_word_t w;
    w = '{op: UOP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (s)
      S_IDLE:  w = '{op: UOP_NOP,   cond: C_NOGO,   target: S_IDLE};
      S_INIT:  w = '{op: UOP_INIT,  cond: C_NONE,   target: S_IDLE};
      S_FETCH: w = '{op: UOP_FETCH, cond: C_NONE,   target: S_IDLE};
      S_LOADV: w = '{op: UOP_LOADV, cond: C_SEED,   target: S_PUSH};
      S_RDT2:  w = '{op: UOP_RDT2,  cond: C_NONE,   target: S_IDLE};
      S_LDT2:  w = '{op: UOP_LDT2,  cond: C_NONE,   target: S_IDLE};
      S_MULA:  w = '{op: UOP_MULA,  cond: C_NONE,   target: S_IDLE};
      S_MULB:  w = '{op: UOP_MULB,  cond: C_NONE,   target: S_IDLE};
      S_TEST:  w = '{op: UOP_NOP,   cond: C_NOPOP,  target: S_PUSH};
      S_POP:   w = '{op: UOP_POP,   cond: C_DEEP,   target: S_RDT2};
      S_PUSH:  w = '{op: UOP_PUSH,  cond: C_MORE,   target: S_FETCH};
      S_RDK:   w = '{op: UOP_RDK,   cond: C_NONE,   target: S_IDLE};
      S_OUT:   w = '{op: UOP_OUT,   cond: C_EMORE,  target: S_RDK};
      S_DONE:  w = '{op: UOP_DONE,  cond: C_ALWAYS, target: S_IDLE};
      default: w = '{op: UOP_NOP,   cond: C_ALWAYS, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/polygon_convex_hull_scan_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_convex_hull_scan_top: convex hull of a polygon, one vertex per item
// Microcoded Graham-style scan over a 64-entry vertex store and hull stack.
// ----------------------------------------------------------------------------
// Loading: one vertex per cycle while busy is low; the last vertex raises busy.
// Scan: each vertex is fetched and pushed; past the seeds a turn test precedes the push
//   (stack read, two passes through the one shared multiplier, compare), redone after a pop.
// Emit: each hull vertex is read through the stack read port, then the run is cleared.
// Results are not stalled by the receiver.
// Reset (synchronous, rst_n low) empties the run.
module polygon_convex_hull_scan_top
  import pcvh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_strobe,
  output out_item_t     out_item
);

  ctrl_word_t cw;
  status_t    status;
  logic       in_accept;

  assign in_accept = start && !busy;

  pcvh_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cw     (cw),
    .busy   (busy)
  );

  pcvh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_item    (in_item),
    .cw         (cw),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/pcvh_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcvh_sequencer: microcode step counter
// Reads one control word per step and resolves the conditional jump.
// ----------------------------------------------------------------------------
module pcvh_sequencer
  import pcvh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire status_t    status,
  output ctrl_word_t      cw,
  output logic            busy
);

  step_t step_r, step_nxt;
  logic  taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    unique case (cw.cond)
      C_NONE:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_NOGO:   taken = !status.go;
      C_SEED:   taken = status.seed;
      C_NOPOP:  taken = status.nopop;
      C_DEEP:   taken = status.deep;
      C_MORE:   taken = status.more;
      C_EMORE:  taken = status.emore;
      default:  taken = 1'b1;
    endcase
    step_nxt = taken ? cw.target : step_t'(step_r + 4'd1);
  end

  always_comb begin
    cw   = ucode_rom(step_r);
    busy = (step_r != S_IDLE);
  end

endmodule
`default_nettype wire

>>> rtl/pcvh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcvh_datapath: vertex store, hull stack and turn-test arithmetic
// Executes one micro-op per cycle; reports condition flags to the sequencer.
// ----------------------------------------------------------------------------
module pcvh_datapath
  import pcvh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_accept,
  input  wire in_item_t   in_item,
  input  wire ctrl_word_t cw,
  output status_t         status,
  output logic            out_strobe,
  output out_item_t       out_item
);

  point_t vs_mem [MAX_VERTICES];
  point_t st_mem [MAX_VERTICES];

  logic [CNT_W-1:0] count_r, depth_r, j_r, k_r;
  logic [IDX_W-1:0] top_idx_r, ptr_r;
  coord_t           top_y_r;
  logic             ovf_r;
  logic             out_strobe_r;
  out_item_t        out_item_r;
  point_t           vs_rd_r, st_rd_r, v_r, t1_r, t2_r;
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;

  logic             store_en;
  logic [IDX_W-1:0] st_raddr;
  logic signed [DIFF_W-1:0] mul_l, mul_r;
  logic signed [PROD_W-1:0] product;

  function automatic logic [IDX_W-1:0] wrap_next(logic [IDX_W-1:0] p,
                                                 logic [CNT_W-1:0] n);
    logic [IDX_W-1:0] r;
    r = (CNT_W'(p) == n - CNT_W'(1)) ? '0 : IDX_W'(p + IDX_W'(1));
    return r;
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff(coord_t a, coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(signed'({a[COORD_BITS-1], a})) - DIFF_W'(signed'({b[COORD_BITS-1], b}));
    return d;
  endfunction

  assign store_en = in_accept && (count_r < CNT_W'(MAX_VERTICES));

  always_comb begin
    if (cw.op == UOP_RDT2) begin
      st_raddr = IDX_W'(depth_r - CNT_W'(T2_OFFSET));
    end else begin
      st_raddr = k_r[IDX_W-1:0];
    end
  end

  // one shared multiplier for both sides of the turn test
  always_comb begin
    if (cw.op == UOP_MULB) begin
      mul_l = diff(t1_r.y, t2_r.y);
      mul_r = diff(v_r.x, t1_r.x);
    end else begin
      mul_l = diff(v_r.y, t1_r.y);
      mul_r = diff(t1_r.x, t2_r.x);
    end
    product = PROD_W'(mul_l) * PROD_W'(mul_r);
  end

  always_comb begin
    status.go    = in_accept && in_item.last_vertex;
    status.seed  = j_r < CNT_W'(SEED_COUNT);
    status.nopop = prod_a_r < prod_b_r;
    status.deep  = depth_r >= CNT_W'(SEED_COUNT);
    status.more  = (j_r + CNT_W'(1)) < count_r;
    status.emore = k_r < depth_r;
  end

  // run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      top_idx_r    <= '0;
      top_y_r      <= TOP_Y_RESET;
      ovf_r        <= 1'b0;
      depth_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cw.op == UOP_OUT);
      if (in_accept) begin
        if (store_en) begin
          if (count_r == '0 || in_item.vertex_y > top_y_r) begin
            top_y_r   <= in_item.vertex_y;
            top_idx_r <= count_r[IDX_W-1:0];
          end
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      unique case (cw.op)
        UOP_INIT: depth_r <= '0;
        UOP_POP:  depth_r <= depth_r - CNT_W'(1);
        UOP_PUSH: depth_r <= depth_r + CNT_W'(1);
        UOP_DONE: begin
          count_r   <= '0;
          top_idx_r <= '0;
          top_y_r   <= TOP_Y_RESET;
          ovf_r     <= 1'b0;
          depth_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  // scan payload registers
  always_ff @(posedge clk) begin
    unique case (cw.op)
      UOP_INIT: begin
        ptr_r <= wrap_next(top_idx_r, count_r);
        j_r   <= '0;
        k_r   <= '0;
      end
      UOP_FETCH: ptr_r <= wrap_next(ptr_r, count_r);
      UOP_LOADV: v_r <= vs_rd_r;
      UOP_LDT2:  t2_r <= st_rd_r;
      UOP_MULA:  prod_a_r <= product;
      UOP_MULB:  prod_b_r <= product;
      UOP_POP:   t1_r <= t2_r;
      UOP_PUSH: begin
        t1_r <= v_r;
        j_r  <= j_r + CNT_W'(1);
      end
      UOP_RDK:   k_r <= k_r + CNT_W'(1);
      UOP_OUT: begin
        out_item_r.hull_x    <= st_rd_r.x;
        out_item_r.hull_y    <= st_rd_r.y;
        out_item_r.hull_last <= (k_r == depth_r);
        out_item_r.overflow  <= ovf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      vs_mem[count_r[IDX_W-1:0]] <= '{x: in_item.vertex_x, y: in_item.vertex_y};
    end
    if (cw.op == UOP_FETCH) begin
      vs_rd_r <= vs_mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == UOP_PUSH) begin
      st_mem[depth_r[IDX_W-1:0]] <= v_r;
    end
    if (cw.op == UOP_RDT2 || cw.op == UOP_RDK) begin
      st_rd_r <= st_mem[st_raddr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == UOP_PUSH) |-> (depth_r <= j_r))
    else $error("push beyond scanned vertex count");

  a_pop_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == UOP_POP) |-> (depth_r >= CNT_W'(T2_OFFSET)))
    else $error("pop below one remaining entry");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_item_r.hull_last) |=> !out_strobe_r)
    else $error("result after final hull vertex");

endmodule
`default_nettype wire
